[rtl/b64e_pkg.sv]
// Shared types, constants and the base64 digit function for the encoder.
package b64e_pkg;

   localparam int GQ_DEPTH = 2;
   localparam int GQ_AW    = 1;

   localparam logic [7:0] PAD_CHAR     = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [9:0] COLUMN_MAX   = 10'h3FF;

   localparam logic [2:0] REG_LINE_SIZE = 3'd0;

   // One group of up to three bytes handed from the front to the back.
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  used;
      logic        fin;
   } grp_type;

   // Head of the group queue as seen by the back.
   typedef struct packed {
      logic    valid;
      grp_type grp;
   } gq_head_type;

   function automatic logic [7:0] b64_digit(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

[rtl/base64_encoder_line_wrap.sv]
// Path: a byte that completes a group, or the final byte, is written into the group queue;
// the back registers its characters onto the result ports; a held byte produces nothing.
// Throughput: the back emits one character per cycle unless a waiting result is not popped;
// a group gives four characters plus inserted newlines; the two-entry group queue absorbs bursts.
// Reset (synchronous) clears pending bytes, queue, column and output valid; line_size = 0.
module base64_encoder_line_wrap import b64e_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_run_last,
   output logic        rsp_text_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [9:0]  line_size_ff;
   logic        gq_full;
   logic        gq_wr;
   grp_type     gq_wdata;
   logic        gq_rd;
   gq_head_type gq_head;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_LINE_SIZE) ? {22'h0, line_size_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_size_ff <= 10'd0;
      end else if (psel && penable && pwrite && pready && !paddr[2]) begin
         line_size_ff <= pwdata[9:0];
      end
   end

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .gq_full    (gq_full),
      .full       (full),
      .gq_wr      (gq_wr),
      .gq_wdata   (gq_wdata)
   );

   b64e_gq u_gq (
      .clock (clock),
      .reset (reset),
      .wr    (gq_wr),
      .wdata (gq_wdata),
      .rd    (gq_rd),
      .full  (gq_full),
      .head  (gq_head)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .line_size (line_size_ff),
      .head      (gq_head),
      .gq_rd     (gq_rd),
      .pop       (pop),
      .empty     (empty),
      .out_char  (rsp_out_char),
      .run_last  (rsp_run_last),
      .text_end  (rsp_text_end)
   );

endmodule

[rtl/b64e_front.sv]
// Front end: gathers bytes in threes and pushes full or final groups.
module b64e_front import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] data_byte,
   input  logic       final_byte,
   input  logic       gq_full,
   output logic       full,
   output logic       gq_wr,
   output grp_type    gq_wdata
);

   logic [15:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        accept;

   assign full   = gq_full;
   assign accept = push & ~gq_full;

   always_comb begin
      gq_wr          = accept & (final_byte | (cnt_ff == 2'd2));
      gq_wdata.fin   = final_byte;
      gq_wdata.bits  = {data_byte, 16'h0000};
      gq_wdata.used  = 2'd1;
      case (cnt_ff)
         2'd0: begin
            gq_wdata.bits = {data_byte, 16'h0000};
            gq_wdata.used = 2'd1;
         end
         2'd1: begin
            gq_wdata.bits = {pend_ff[7:0], data_byte, 8'h00};
            gq_wdata.used = 2'd2;
         end
         default: begin
            gq_wdata.bits = {pend_ff, data_byte};
            gq_wdata.used = 2'd3;
         end
      endcase

      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      if (gq_wr) begin
         pend_in = 16'h0000;
         cnt_in  = 2'd0;
      end else if (accept) begin
         pend_in = {pend_ff[7:0], data_byte};
         cnt_in  = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 16'h0000;
         cnt_ff  <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

[rtl/b64e_gq.sv]
// Short group queue between the front and the back.
module b64e_gq import b64e_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr,
   input  grp_type     wdata,
   input  logic        rd,
   output logic        full,
   output gq_head_type head
);

   grp_type               mem [GQ_DEPTH];
   logic [GQ_AW-1:0]      wptr_ff, rptr_ff;
   logic [GQ_AW:0]        cnt_ff, cnt_in;
   logic                  do_rd;

   assign full       = (cnt_ff == GQ_DEPTH[GQ_AW:0]);
   assign head.valid = (cnt_ff != '0);
   assign head.grp   = mem[rptr_ff];
   assign do_rd      = rd & head.valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr && do_rd) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (do_rd) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

endmodule

[rtl/b64e_back.sv]
// Back end: turns queued groups into characters with line wrapping.
module b64e_back import b64e_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [9:0]  line_size,
   input  gq_head_type head,
   output logic        gq_rd,
   input  logic        pop,
   output logic        empty,
   output logic [7:0]  out_char,
   output logic        run_last,
   output logic        text_end
);

   logic [1:0] idx_ff, idx_in;
   logic [9:0] col_ff, col_in;
   logic       ovld_ff, ovld_in;
   logic [7:0] ochar_ff, ochar_in;
   logic       olast_ff, olast_in;
   logic       oend_ff, oend_in;
   logic       go;
   logic       need_nl;
   logic [5:0] sextet;
   logic       pad;

   assign empty    = ~ovld_ff;
   assign out_char = ochar_ff;
   assign run_last = olast_ff;
   assign text_end = oend_ff;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = head.grp.bits[23:18];
         2'd1:    sextet = head.grp.bits[17:12];
         2'd2:    sextet = head.grp.bits[11:6];
         default: sextet = head.grp.bits[5:0];
      endcase
      pad     = (idx_ff > head.grp.used);
      go      = head.valid & (~ovld_ff | pop);
      need_nl = (line_size != 10'd0) && (col_ff == line_size);

      idx_in   = idx_ff;
      col_in   = col_ff;
      ovld_in  = ovld_ff & ~pop;
      ochar_in = ochar_ff;
      olast_in = olast_ff;
      oend_in  = oend_ff;
      gq_rd    = 1'b0;

      if (go) begin
         ovld_in = 1'b1;
         if (need_nl) begin
            ochar_in = NEWLINE_CHAR;
            olast_in = 1'b0;
            oend_in  = 1'b0;
            col_in   = 10'd0;
         end else begin
            ochar_in = pad ? PAD_CHAR : b64_digit(sextet);
            olast_in = (idx_ff == 2'd3);
            oend_in  = (idx_ff == 2'd3) & head.grp.fin;
            col_in   = (col_ff < COLUMN_MAX) ? col_ff + 10'd1 : col_ff;
            idx_in   = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               gq_rd = 1'b1;
               if (head.grp.fin) begin
                  col_in = 10'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         col_ff   <= 10'd0;
         ovld_ff  <= 1'b0;
         olast_ff <= 1'b0;
         oend_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         col_ff   <= col_in;
         ovld_ff  <= ovld_in;
         olast_ff <= olast_in;
         oend_ff  <= oend_in;
      end
      ochar_ff <= ochar_in;
   end

endmodule

[rtl/b64e_checker.sv]
// Port-level checker for the base64 encoder and its bind to the top level.
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_last,
   input logic       rsp_text_end
);

   // end of message is always the last character of its group
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_text_end) |-> rsp_run_last)
      else $error("text_end without run_last");

   // a newline is never the last character of a group's run
   a_nl_not_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_out_char == 8'h0A) |-> !rsp_run_last)
      else $error("newline closes a run");

   // a waiting result holds until transferred
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_char) && $stable(rsp_run_last)))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result present after reset");

endmodule

bind base64_encoder_line_wrap b64e_checker u_b64e_checker (
   .clock        (clock),
   .reset        (reset),
   .empty        (empty),
   .pop          (pop),
   .rsp_out_char (rsp_out_char),
   .rsp_run_last (rsp_run_last),
   .rsp_text_end (rsp_text_end)
);
